@@ rtl/two_level_lru_cache_tracker_macros.svh @@
// Assertion macros shared by the checker of the two-level LRU cache tracker.
`ifndef TWO_LEVEL_LRU_CACHE_TRACKER_MACROS_SVH
`define TWO_LEVEL_LRU_CACHE_TRACKER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TLLC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tllc: check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define TLLC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tllc: check failed");

`endif

@@ rtl/tllc_pkg.sv @@
// Package with the types, constants and helpers of the two-level LRU cache tracker.
package tllc_pkg;

   localparam int ADDR_BITS = 13;
   localparam int TAG_BITS = 13;
   localparam int ROW_BITS = 8;
   localparam int ROWS = 1 << ROW_BITS;
   localparam int MAX_WAYS = 16;
   localparam int WAYS_BITS = 5;
   localparam int AGE_BITS = 4;
   localparam int MAX_BSHIFT = 6;
   localparam int MAX_RSHIFT = 8;

   // Configuration register indexes.
   localparam logic [2:0] CSR_L1_WAYS = 3'd0;
   localparam logic [2:0] CSR_L1_BSHIFT = 3'd1;
   localparam logic [2:0] CSR_L1_RSHIFT = 3'd2;
   localparam logic [2:0] CSR_L2_ENABLE = 3'd3;
   localparam logic [2:0] CSR_L2_WAYS = 3'd4;
   localparam logic [2:0] CSR_L2_BSHIFT = 3'd5;
   localparam logic [2:0] CSR_L2_RSHIFT = 3'd6;

   // Access status codes.
   localparam logic [1:0] ST_LOAD_HIT = 2'd0;
   localparam logic [1:0] ST_LOAD_MISS = 2'd1;
   localparam logic [1:0] ST_STORE = 2'd2;
   localparam logic [1:0] ST_UNUSED = 2'd3;

   // Cache level codes.
   localparam logic LVL_FIRST = 1'b0;
   localparam logic LVL_SECOND = 1'b1;

   typedef struct packed {
      logic [WAYS_BITS-1:0] l1_ways;
      logic [2:0] l1_bshift;
      logic [3:0] l1_rshift;
      logic l2_en;
      logic [WAYS_BITS-1:0] l2_ways;
      logic [2:0] l2_bshift;
      logic [3:0] l2_rshift;
   } cfg_type;

   // One classified item waiting for the back end.
   typedef struct packed {
      logic store;
      logic [ROW_BITS-1:0] row1;
      logic [TAG_BITS-1:0] tag1;
      logic [ROW_BITS-1:0] row2;
      logic [TAG_BITS-1:0] tag2;
   } qent_type;

   // Command from the back end to one level unit.
   typedef struct packed {
      logic rd;
      logic upd;
      logic [ROW_BITS-1:0] row;
      logic [TAG_BITS-1:0] tag;
      logic [WAYS_BITS-1:0] ways;
   } lvl_cmd_type;

   typedef struct packed {
      logic vld;
      logic [AGE_BITS-1:0] age;
      logic [TAG_BITS-1:0] tag;
   } way_type;

   typedef way_type [MAX_WAYS-1:0] row_type;

   // Zero ways means one; anything above the maximum saturates.
   function automatic logic [WAYS_BITS-1:0] clamp_ways(input logic [WAYS_BITS-1:0] w);
      logic [WAYS_BITS-1:0] r;
      r = w;
      if (w == '0) r = WAYS_BITS'(1);
      else if (w > WAYS_BITS'(MAX_WAYS)) r = WAYS_BITS'(MAX_WAYS);
      return r;
   endfunction

endpackage

@@ rtl/two_level_lru_cache_tracker.sv @@
// Top level of the two-level LRU cache tracker: configuration registers and wiring.
//
// Usage: raise start with req_type (0 load, 1 store) and req_word_address; the
// item is taken at a clock edge where start is high and busy is low. busy is
// high only while the two-entry queue between front and back end is full.
// Each item gives one report for level one and, when level two is enabled
// and the access is a store or a level-one load miss, a second report for
// level two. Reports appear on the rsp_ ports for one cycle each with
// rsp_strobe high; rsp_last_report marks the final report of an item. The
// receiver cannot stall, so results are never held back.
// The first report is registered once level one has read and updated its row;
// the second report comes in the cycle right after it. The back end takes a new
// item only once it is back in idle, after the read and write-back of a tag
// row in each level's row memory that the item uses.
// Configuration: csr_write_enable with csr_index and csr_write_data writes
// one register per edge; write only while idle. Reset restores one way,
// zero shifts, level two off, and marks every row of both levels empty.
module two_level_lru_cache_tracker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_type,
   input  logic [tllc_pkg::ADDR_BITS-1:0] req_word_address,
   output logic rsp_strobe,
   output logic rsp_cache_level,
   output logic [1:0] rsp_access_status,
   output logic [tllc_pkg::ROW_BITS-1:0] rsp_set_row,
   output logic rsp_last_report,
   input  logic csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [tllc_pkg::WAYS_BITS-1:0] csr_write_data
);
   import tllc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   qent_type push_data, head;
   logic push, pop, q_empty, q_full;
   lvl_cmd_type cmd1, cmd2;
   logic hit1, hit2;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_L1_WAYS: cfg_in.l1_ways = csr_write_data;
            CSR_L1_BSHIFT: cfg_in.l1_bshift = csr_write_data[2:0];
            CSR_L1_RSHIFT: cfg_in.l1_rshift = csr_write_data[3:0];
            CSR_L2_ENABLE: cfg_in.l2_en = csr_write_data[0];
            CSR_L2_WAYS: cfg_in.l2_ways = csr_write_data;
            CSR_L2_BSHIFT: cfg_in.l2_bshift = csr_write_data[2:0];
            CSR_L2_RSHIFT: cfg_in.l2_rshift = csr_write_data[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{l1_ways: WAYS_BITS'(1), l1_bshift: 3'd0, l1_rshift: 4'd0,
                     l2_en: 1'b0, l2_ways: WAYS_BITS'(1), l2_bshift: 3'd0,
                     l2_rshift: 4'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tllc_front u_front (
      .start(start), .req_type(req_type), .req_word_address(req_word_address),
      .cfg(cfg_ff), .q_full(q_full), .busy(busy), .push(push), .push_data(push_data)
   );

   tllc_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data), .pop(pop),
      .head(head), .empty(q_empty), .full(q_full)
   );

   tllc_level u_level1 (.clock(clock), .reset(reset), .cmd(cmd1), .hit(hit1));
   tllc_level u_level2 (.clock(clock), .reset(reset), .cmd(cmd2), .hit(hit2));

   tllc_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_empty(q_empty), .head(head),
      .pop(pop), .cmd1(cmd1), .cmd2(cmd2), .hit1(hit1), .hit2(hit2),
      .rsp_strobe(rsp_strobe), .rsp_cache_level(rsp_cache_level),
      .rsp_access_status(rsp_access_status), .rsp_set_row(rsp_set_row),
      .rsp_last_report(rsp_last_report)
   );

endmodule

@@ rtl/tllc_fifo.sv @@
// Two-entry queue between the front end and the back end.
module tllc_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  tllc_pkg::qent_type push_data,
   input  logic pop,
   output tllc_pkg::qent_type head,
   output logic empty,
   output logic full
);
   import tllc_pkg::*;

   qent_type mem_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign empty = (cnt_ff == 2'd0);
   assign full = (cnt_ff == 2'd2);
   assign head = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

@@ rtl/tllc_front.sv @@
// Front end: accepts items and splits the address into row and tag for both levels.
module tllc_front (
   input  logic start,
   input  logic req_type,
   input  logic [tllc_pkg::ADDR_BITS-1:0] req_word_address,
   input  tllc_pkg::cfg_type cfg,
   input  logic q_full,
   output logic busy,
   output logic push,
   output tllc_pkg::qent_type push_data
);
   import tllc_pkg::*;

   logic [2:0] bs1, bs2;
   logic [3:0] rs1, rs2;
   logic [ADDR_BITS-1:0] blk1, blk2;

   assign busy = q_full;
   assign push = start && !q_full;

   // Saturate the shifts, then split block into row and tag.
   always_comb begin
      bs1 = (cfg.l1_bshift > 3'(MAX_BSHIFT)) ? 3'(MAX_BSHIFT) : cfg.l1_bshift;
      bs2 = (cfg.l2_bshift > 3'(MAX_BSHIFT)) ? 3'(MAX_BSHIFT) : cfg.l2_bshift;
      rs1 = (cfg.l1_rshift > 4'(MAX_RSHIFT)) ? 4'(MAX_RSHIFT) : cfg.l1_rshift;
      rs2 = (cfg.l2_rshift > 4'(MAX_RSHIFT)) ? 4'(MAX_RSHIFT) : cfg.l2_rshift;
      blk1 = req_word_address >> bs1;
      blk2 = req_word_address >> bs2;
      push_data.store = req_type;
      push_data.row1 = blk1[ROW_BITS-1:0] & ~({ROW_BITS{1'b1}} << rs1);
      push_data.tag1 = TAG_BITS'(blk1 >> rs1);
      push_data.row2 = blk2[ROW_BITS-1:0] & ~({ROW_BITS{1'b1}} << rs2);
      push_data.tag2 = TAG_BITS'(blk2 >> rs2);
   end

endmodule

@@ rtl/tllc_level.sv @@
// One cache level: row memory with per-row valid flags and the LRU row update.
module tllc_level (
   input  logic clock,
   input  logic reset,
   input  tllc_pkg::lvl_cmd_type cmd,
   output logic hit
);
   import tllc_pkg::*;

   row_type mem [ROWS];
   logic [ROWS-1:0] rowv_ff;
   row_type rdata_ff;
   logic rd_rowv_ff;
   logic [ROW_BITS-1:0] row_ff;

   row_type cur, nxt;
   logic [MAX_WAYS-1:0] vld, match, hit_oh, old_oh, free_oh, ins_oh;
   logic [AGE_BITS-1:0] age_hit;
   logic [WAYS_BITS-1:0] cnt;
   logic evict;

   // Registered row read.
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff <= mem[cmd.row];
         rd_rowv_ff <= rowv_ff[cmd.row];
         row_ff <= cmd.row;
      end
   end

   // Row write-back.
   always_ff @(posedge clock) begin
      if (cmd.upd) mem[row_ff] <= nxt;
   end

   // A row never written reads as all ways empty with zero ages.
   always_ff @(posedge clock) begin
      if (reset) rowv_ff <= '0;
      else if (cmd.upd) rowv_ff[row_ff] <= 1'b1;
   end

   // Classify the ways of the row that was read.
   always_comb begin
      cnt = '0;
      age_hit = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         cur[w].vld = rdata_ff[w].vld && rd_rowv_ff;
         cur[w].age = rd_rowv_ff ? rdata_ff[w].age : '0;
         cur[w].tag = rdata_ff[w].tag;
         vld[w] = cur[w].vld;
         match[w] = cur[w].vld && (cur[w].tag == cmd.tag);
         cnt = cnt + WAYS_BITS'(cur[w].vld);
      end
      hit_oh = match & (~match + MAX_WAYS'(1));
      free_oh = ~vld & (vld + MAX_WAYS'(1));
      hit = |match;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (hit_oh[w]) age_hit = age_hit | cur[w].age;
      end
      // Oldest way: the last valid way holding the largest age.
      for (int w = 0; w < MAX_WAYS; w++) begin
         old_oh[w] = vld[w];
         for (int v = 0; v < MAX_WAYS; v++) begin
            if (vld[v] && v < w && cur[v].age > cur[w].age) old_oh[w] = 1'b0;
            if (vld[v] && v > w && cur[v].age >= cur[w].age) old_oh[w] = 1'b0;
         end
      end
      evict = !hit && (cnt >= cmd.ways);
      ins_oh = evict ? old_oh : free_oh;
   end

   // New row contents after the hit or the miss.
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         nxt[w] = cur[w];
         if (hit) begin
            if (cur[w].vld && cur[w].age < age_hit) nxt[w].age = cur[w].age + 1'b1;
            if (hit_oh[w]) nxt[w].age = '0;
         end else begin
            if (evict && old_oh[w]) begin
               nxt[w].vld = 1'b0;
               nxt[w].age = '0;
            end else if (cur[w].vld && cur[w].age != {AGE_BITS{1'b1}}) begin
               nxt[w].age = cur[w].age + 1'b1;
            end
            if (ins_oh[w]) begin
               nxt[w].vld = 1'b1;
               nxt[w].tag = cmd.tag;
               nxt[w].age = '0;
            end
         end
      end
   end

endmodule

@@ rtl/tllc_back.sv @@
// Back end: runs each queued item through level one and, when needed, level two.
module tllc_back (
   input  logic clock,
   input  logic reset,
   input  tllc_pkg::cfg_type cfg,
   input  logic q_empty,
   input  tllc_pkg::qent_type head,
   output logic pop,
   output tllc_pkg::lvl_cmd_type cmd1,
   output tllc_pkg::lvl_cmd_type cmd2,
   input  logic hit1,
   input  logic hit2,
   output logic rsp_strobe,
   output logic rsp_cache_level,
   output logic [1:0] rsp_access_status,
   output logic [tllc_pkg::ROW_BITS-1:0] rsp_set_row,
   output logic rsp_last_report
);
   import tllc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EV1 = 3'b010,
      S_EV2 = 3'b100
   } state_type;

   state_type state_ff, state_in;
   qent_type item_ff, item_in;
   logic strobe_ff, strobe_in;
   logic level_ff, level_in;
   logic [1:0] status_ff, status_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic last_ff, last_in;
   logic use2;

   // Sequencer: read row, update and report, then the second level if needed.
   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      pop = 1'b0;
      cmd1 = '0;
      cmd2 = '0;
      strobe_in = 1'b0;
      level_in = level_ff;
      status_in = status_ff;
      row_in = row_ff;
      last_in = last_ff;
      use2 = cfg.l2_en && (item_ff.store || !hit1);
      cmd1.tag = item_ff.tag1;
      cmd1.ways = clamp_ways(cfg.l1_ways);
      cmd2.tag = item_ff.tag2;
      cmd2.ways = clamp_ways(cfg.l2_ways);
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               item_in = head;
               cmd1.rd = 1'b1;
               cmd1.row = head.row1;
               state_in = S_EV1;
            end
         end
         S_EV1: begin
            cmd1.upd = 1'b1;
            strobe_in = 1'b1;
            level_in = LVL_FIRST;
            status_in = item_ff.store ? ST_STORE : (hit1 ? ST_LOAD_HIT : ST_LOAD_MISS);
            row_in = item_ff.row1;
            last_in = !use2;
            if (use2) begin
               cmd2.rd = 1'b1;
               cmd2.row = item_ff.row2;
               state_in = S_EV2;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EV2: begin
            cmd2.upd = 1'b1;
            strobe_in = 1'b1;
            level_in = LVL_SECOND;
            status_in = item_ff.store ? ST_STORE : (hit2 ? ST_LOAD_HIT : ST_LOAD_MISS);
            row_in = item_ff.row2;
            last_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Item and result payload.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      level_ff <= level_in;
      status_ff <= status_in;
      row_ff <= row_in;
      last_ff <= last_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_cache_level = level_ff;
   assign rsp_access_status = status_ff;
   assign rsp_set_row = row_ff;
   assign rsp_last_report = last_ff;

endmodule

@@ rtl/tllc_checker.sv @@
// Port-level checker for the two-level LRU cache tracker, bound to the top level.
`include "two_level_lru_cache_tracker_macros.svh"

module tllc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_strobe,
   input logic rsp_cache_level,
   input logic [1:0] rsp_access_status,
   input logic rsp_last_report
);
   import tllc_pkg::*;

   // A non-final report comes from level one and is followed by the level-two report.
   `TLLC_ASSERT_IMP(a_first_from_l1, rsp_strobe && !rsp_last_report, rsp_cache_level == LVL_FIRST)
   `TLLC_ASSERT_NEXT(a_second_follows, rsp_strobe && !rsp_last_report, rsp_strobe && rsp_last_report && rsp_cache_level == LVL_SECOND)
   // A store reports as a store at both levels.
   `TLLC_ASSERT_NEXT(a_store_kept, rsp_strobe && !rsp_last_report && rsp_access_status == ST_STORE, rsp_access_status == ST_STORE)
   // The unused status code never appears.
   `TLLC_ASSERT_IMP(a_status_code, rsp_strobe, rsp_access_status != ST_UNUSED)

endmodule

bind two_level_lru_cache_tracker tllc_checker u_tllc_checker (.*);

@@ test/lru_checker.sv @@
// Checker for the two-level LRU cache tracker: predicts every report and compares it.
module lru_checker
   import tllc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  logic req_type,
   input  logic [ADDR_BITS-1:0] req_word_address,
   input  logic rsp_strobe,
   input  logic rsp_cache_level,
   input  logic [1:0] rsp_access_status,
   input  logic [ROW_BITS-1:0] rsp_set_row,
   input  logic rsp_last_report,
   input  logic csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [WAYS_BITS-1:0] csr_write_data,
   output int mismatches,
   output int pending,
   output int reports_seen,
   output int hits_seen
);

   typedef struct packed {
      logic level;
      logic [1:0] status;
      logic [ROW_BITS-1:0] row;
      logic last;
   } report_type;

   report_type expected_reports[$];

   // Shadow copy of the configuration registers.
   logic [WAYS_BITS-1:0] l1_ways, l2_ways;
   logic [2:0] l1_bshift, l2_bshift;
   logic [3:0] l1_rshift, l2_rshift;
   logic l2_en;

   // Shadow tag store, indexed by level, row and way.
   logic dir_valid[2][ROWS][MAX_WAYS];
   logic [AGE_BITS-1:0] dir_age[2][ROWS][MAX_WAYS];
   logic [TAG_BITS-1:0] dir_tag[2][ROWS][MAX_WAYS];

   // Look up one level, update its LRU state and report hit and row.
   function automatic logic lookup_level(input int lvl, input logic [ADDR_BITS-1:0] addr,
                                         input logic [WAYS_BITS-1:0] ways_reg,
                                         input logic [2:0] bsh, input logic [3:0] rsh,
                                         output logic [ROW_BITS-1:0] row_out);
      int ways, bs, rs, blk, row, count, hit_way, free_way, old_way;
      logic [TAG_BITS-1:0] tag;
      logic [AGE_BITS-1:0] old_age, hit_age;
      ways = (ways_reg == 0) ? 1 : (ways_reg > MAX_WAYS ? MAX_WAYS : int'(ways_reg));
      bs = (bsh > MAX_BSHIFT) ? MAX_BSHIFT : int'(bsh);
      rs = (rsh > MAX_RSHIFT) ? MAX_RSHIFT : int'(rsh);
      blk = int'(addr) >> bs;
      row = blk & ((1 << rs) - 1);
      tag = TAG_BITS'(blk >> rs);
      row_out = ROW_BITS'(row);
      count = 0;
      hit_way = -1;
      free_way = -1;
      old_way = -1;
      old_age = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (dir_valid[lvl][row][w]) begin
            count++;
            if (dir_tag[lvl][row][w] == tag && hit_way < 0) hit_way = w;
            if (old_way < 0 || dir_age[lvl][row][w] >= old_age) begin
               old_way = w;
               old_age = dir_age[lvl][row][w];
            end
         end else if (free_way < 0) begin
            free_way = w;
         end
      end
      // A hit ages the younger entries and makes the hit entry most recent.
      if (hit_way >= 0) begin
         hit_age = dir_age[lvl][row][hit_way];
         for (int w = 0; w < MAX_WAYS; w++)
            if (dir_valid[lvl][row][w] && dir_age[lvl][row][w] < hit_age)
               dir_age[lvl][row][w]++;
         dir_age[lvl][row][hit_way] = '0;
         return 1'b1;
      end
      // A miss evicts the oldest entry once the row is full, then inserts.
      if (count >= ways && old_way >= 0) begin
         dir_valid[lvl][row][old_way] = 1'b0;
         dir_age[lvl][row][old_way] = '0;
         free_way = old_way;
      end
      for (int w = 0; w < MAX_WAYS; w++)
         if (dir_valid[lvl][row][w] && dir_age[lvl][row][w] < 4'd15)
            dir_age[lvl][row][w]++;
      dir_valid[lvl][row][free_way] = 1'b1;
      dir_tag[lvl][row][free_way] = tag;
      dir_age[lvl][row][free_way] = '0;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      logic hit1, hit2, use2;
      logic [ROW_BITS-1:0] row1, row2;
      report_type got, want;
      if (reset) begin
         l1_ways = 5'd1; l1_bshift = '0; l1_rshift = '0; l2_en = 1'b0;
         l2_ways = 5'd1; l2_bshift = '0; l2_rshift = '0;
         for (int l = 0; l < 2; l++)
            for (int r = 0; r < ROWS; r++)
               for (int w = 0; w < MAX_WAYS; w++) begin
                  dir_valid[l][r][w] = 1'b0;
                  dir_age[l][r][w] = '0;
               end
         expected_reports.delete();
      end else begin
         // Track configuration writes.
         if (csr_write_enable) begin
            case (csr_index)
               CSR_L1_WAYS:   l1_ways = csr_write_data;
               CSR_L1_BSHIFT: l1_bshift = csr_write_data[2:0];
               CSR_L1_RSHIFT: l1_rshift = csr_write_data[3:0];
               CSR_L2_ENABLE: l2_en = csr_write_data[0];
               CSR_L2_WAYS:   l2_ways = csr_write_data;
               CSR_L2_BSHIFT: l2_bshift = csr_write_data[2:0];
               CSR_L2_RSHIFT: l2_rshift = csr_write_data[3:0];
               default: ;
            endcase
         end
         // Predict the reports of an accepted item.
         if (start && !busy) begin
            hit1 = lookup_level(0, req_word_address, l1_ways, l1_bshift, l1_rshift, row1);
            use2 = l2_en && (req_type || !hit1);
            want = '{LVL_FIRST,
               req_type ? ST_STORE : (hit1 ? ST_LOAD_HIT : ST_LOAD_MISS), row1, !use2};
            expected_reports.insert(expected_reports.size(), want);
            if (use2) begin
               hit2 = lookup_level(1, req_word_address, l2_ways, l2_bshift, l2_rshift, row2);
               want = '{LVL_SECOND,
                  req_type ? ST_STORE : (hit2 ? ST_LOAD_HIT : ST_LOAD_MISS), row2, 1'b1};
               expected_reports.insert(expected_reports.size(), want);
            end
         end
         // Compare each report with the oldest prediction.
         if (rsp_strobe) begin
            got = '{rsp_cache_level, rsp_access_status, rsp_set_row, rsp_last_report};
            reports_seen++;
            if (rsp_access_status == ST_LOAD_HIT) hits_seen++;
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected report: level %0d status %0d row %0d last %0d",
                           got.level, got.status, got.row, got.last);
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"report mismatch: expected level %0d status %0d row %0d",
                               " last %0d, got level %0d status %0d row %0d last %0d"},
                              want.level, want.status, want.row, want.last,
                              got.level, got.status, got.row, got.last);
               end
            end
         end
      end
      pending = expected_reports.size();
   end

endmodule

@@ test/testbench.sv @@
// Top of the testbench: stimulus for the cache tracker, the checker and the verdict.
module testbench;
   import tllc_pkg::*;

   logic clock, reset, start, busy, req_type;
   logic [ADDR_BITS-1:0] req_word_address;
   logic rsp_strobe, rsp_cache_level, rsp_last_report;
   logic [1:0] rsp_access_status;
   logic [ROW_BITS-1:0] rsp_set_row;
   logic csr_write_enable;
   logic [2:0] csr_index;
   logic [WAYS_BITS-1:0] csr_write_data;
   int mismatches, pending, reports_seen, hits_seen;
   int items_sent;
   logic [ADDR_BITS-1:0] hot_addrs[12];

   two_level_lru_cache_tracker DUT (.*);
   lru_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Write one configuration register; the caller drops the write enable.
   task automatic write_reg(input logic [2:0] idx, input logic [WAYS_BITS-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
   endtask

   task automatic write_config(input int w1, b1, r1, en, w2, b2, r2);
      write_reg(CSR_L1_WAYS, WAYS_BITS'(w1));
      write_reg(CSR_L1_BSHIFT, WAYS_BITS'(b1));
      write_reg(CSR_L1_RSHIFT, WAYS_BITS'(r1));
      write_reg(CSR_L2_ENABLE, WAYS_BITS'(en));
      write_reg(CSR_L2_WAYS, WAYS_BITS'(w2));
      write_reg(CSR_L2_BSHIFT, WAYS_BITS'(b2));
      write_reg(CSR_L2_RSHIFT, WAYS_BITS'(r2));
      csr_write_enable <= 1'b0;
   endtask

   // Offer one item, keep start high until it is taken, then maybe idle.
   task automatic issue(input logic kind, input logic [ADDR_BITS-1:0] addr, input int gap);
      start <= 1'b1;
      req_type <= kind;
      req_word_address <= addr;
      do @(posedge clock); while (busy);
      items_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Let every predicted report drain, then cover the block's latency.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int burst, gap;
      logic [ADDR_BITS-1:0] addr;
      reset = 1'b1;
      start = 1'b0;
      req_type = 1'b0;
      req_word_address = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      items_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset configuration, one way, single row, first level only.
      issue(1'b0, 13'd0, 0);
      issue(1'b0, 13'd0, 0);
      issue(1'b1, 13'd8191, 1);
      issue(1'b0, 13'd8191, 0);
      issue(1'b0, 13'd1, 2);
      drain();

      // Directed: both levels, moderate split.
      write_config(2, 1, 2, 1, 4, 0, 3);
      issue(1'b0, 13'd0, 0);
      issue(1'b0, 13'd1, 0);
      issue(1'b1, 13'd5, 0);
      issue(1'b0, 13'd8191, 0);
      issue(1'b0, 13'd8190, 3);
      issue(1'b0, 13'd5, 0);
      drain();

      // Directed: out-of-range register values that saturate, and zero ways.
      write_config(31, 7, 15, 1, 0, 7, 15);
      issue(1'b0, 13'd8191, 0);
      issue(1'b0, 13'd0, 0);
      issue(1'b1, 13'h1555, 0);
      issue(1'b0, 13'h0AAA, 0);
      issue(1'b0, 13'd8191, 1);
      drain();

      // Directed: largest legal values.
      write_config(16, 6, 8, 1, 16, 6, 8);
      issue(1'b0, 13'd4095, 0);
      issue(1'b1, 13'd4096, 0);
      issue(1'b0, 13'd4095, 0);
      drain();

      // Random phases, each with a fresh configuration and a hot address pool.
      for (int phase = 0; phase < 14; phase++) begin
         if (phase % 5 == 4)
            write_config($urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 15),
                         $urandom_range(0, 1), $urandom_range(0, 31), $urandom_range(0, 7),
                         $urandom_range(0, 15));
         else
            write_config($urandom_range(1, 4), $urandom_range(0, 3), $urandom_range(0, 3),
                         ($urandom_range(0, 3) != 0), $urandom_range(1, 8),
                         $urandom_range(0, 4), $urandom_range(0, 5));
         foreach (hot_addrs[i]) hot_addrs[i] = ADDR_BITS'($urandom_range(0, 8191));
         for (int n = 0; n < 130;) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && n < 130; b++, n++) begin
               addr = ($urandom_range(0, 9) < 7) ? hot_addrs[$urandom_range(0, 11)]
                                                : ADDR_BITS'($urandom_range(0, 8191));
               gap = (b == burst - 1) ? $urandom_range(0, 7) : 0;
               issue(1'($urandom_range(0, 1)), addr, gap);
            end
         end
         drain();
      end

      // Final wait is done by the last drain; give the verdict.
      $display("Covered %0d items over 18 configurations: %0d reports checked, %0d load hits.",
               items_sent, reports_seen, hits_seen);
      if (mismatches == 0 && pending == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   initial begin
      #3000000;
      $display("testbench: errors");
      $finish;
   end

endmodule
